// ===== rtl/ps2_mouse_packet_cursor_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// ps2 mouse cursor tracker assertion macros
// concurrent checks on clk_i, held off during reset, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PS2MCT_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PS2MCT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`else

`define PS2MCT_ASSERT_NOW(lbl, ant, cons, msg)
`define PS2MCT_ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

// ===== rtl/ps2mct_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mct_pkg
// shared constants of the ps2 mouse packet cursor tracker
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int FieldBits        = 12;
  localparam int ByteBits         = 8;
  localparam int CoordBitsDefault = 12;
  localparam int CfgIdxBits       = 1;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = 1'b1;

  // flag byte bits
  localparam int ResyncBit = 3;
  localparam int XSignBit  = 4;
  localparam int YSignBit  = 5;
  localparam int LeftBit   = 0;
  localparam logic [ByteBits-1:0] OverflowMask = 8'hC0;

  // reset values
  localparam logic [FieldBits-1:0] ScreenWidthReset  = 12'd1280;
  localparam logic [FieldBits-1:0] ScreenHeightReset = 12'd800;
  localparam int PosXReset = 640;
  localparam int PosYReset = 400;

endpackage

// ===== rtl/ps2_mouse_packet_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// frames a ps/2 mouse byte stream into 3-byte packets and tracks a cursor
// ----------------------------------------------------------------------------
// path: the last byte of a packet goes to the byte register, then its result to the result register
// throughput: one byte per cycle; the byte register and the result register
// set the pace, a byte that ends a packet waits only while the result is held
// reset: cursor at (640, 400) masked to COORD_BITS, bounds 1280 x 800,
// framer waiting for a flag byte, left button released, no item in flight
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = ps2mct_pkg::CoordBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ps2mct_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ps2mct_pkg::FieldBits-1:0]    cfg_wdata_i,
  // byte stream
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ps2mct_pkg::ByteBits-1:0]     stream_byte_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ps2mct_pkg::FieldBits-1:0]    cursor_x_o,
  output logic [ps2mct_pkg::FieldBits-1:0]    cursor_y_o,
  output logic                                moved_o,
  output logic                                left_pressed_o,
  output logic                                button_changed_o
);
  import ps2mct_pkg::*;

  // signed working width: holds coordinate, bound and a 9-bit delta
  localparam int SW = ((COORD_BITS > FieldBits) ? COORD_BITS : FieldBits) + 2;
  localparam logic [SW-1:0] CoordMax = SW'((1 << COORD_BITS) - 1);
  localparam logic [COORD_BITS-1:0] XReset = COORD_BITS'(PosXReset);
  localparam logic [COORD_BITS-1:0] YReset = COORD_BITS'(PosYReset);

  typedef enum logic [1:0] {
    POS_FLAGS,
    POS_XDELTA,
    POS_YDELTA
  } pos_e;

  pos_e                  pos_q, pos_d;
  logic [ByteBits-1:0]   flag_q, flag_d;
  logic [ByteBits-1:0]   xbyte_q, xbyte_d;
  logic [COORD_BITS-1:0] px_q, px_d;
  logic [COORD_BITS-1:0] py_q, py_d;
  logic                  left_q, left_d;
  logic [FieldBits-1:0]  width_q, width_d;
  logic [FieldBits-1:0]  height_q, height_d;

  logic                  byte_vld_q, byte_vld_d;
  logic [ByteBits-1:0]   byte_q, byte_d;

  logic                  out_vld_q, out_vld_d;
  logic [FieldBits-1:0]  ox_q, ox_d;
  logic [FieldBits-1:0]  oy_q, oy_d;
  logic                  omoved_q, omoved_d;
  logic                  oleft_q, oleft_d;
  logic                  ochg_q, ochg_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  last_byte;
  logic                  make_result;
  logic                  proc_go;
  logic                  byte_free;
  logic                  load_result;

  logic signed [8:0]     dx, dy;
  logic                  moved;
  logic [SW-1:0]         lim_x, lim_y;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic [COORD_BITS-1:0] cx, cy;
  logic [SW-1:0]         ext_x, ext_y;

  // handshake
  always_comb begin
    last_byte   = byte_vld_q && (pos_q == POS_YDELTA);
    make_result = last_byte && ((flag_q & OverflowMask) == '0);
    out_free    = !out_vld_q || !out_stall_i;
    proc_go     = byte_vld_q && (!make_result || out_free);
    byte_free   = !byte_vld_q || proc_go;
    in_accept   = in_valid_i && byte_free;
    load_result = proc_go && make_result;
  end

  assign in_stall_o = !byte_free;

  // delta decode and clamp
  always_comb begin
    dx    = {flag_q[XSignBit], xbyte_q};
    dy    = {flag_q[YSignBit], byte_q};
    moved = (dx != '0) || (dy != '0);

    lim_x = (SW'(width_q) > CoordMax) ? CoordMax : SW'(width_q);
    lim_y = (SW'(height_q) > CoordMax) ? CoordMax : SW'(height_q);

    sum_x = $signed(SW'(px_q)) + $signed({{(SW-9){dx[8]}}, dx});
    sum_y = $signed(SW'(py_q)) - $signed({{(SW-9){dy[8]}}, dy});

    if (sum_x[SW-1]) begin
      cx = '0;
    end else if ($unsigned(sum_x) > lim_x) begin
      cx = lim_x[COORD_BITS-1:0];
    end else begin
      cx = sum_x[COORD_BITS-1:0];
    end

    if (sum_y[SW-1]) begin
      cy = '0;
    end else if ($unsigned(sum_y) > lim_y) begin
      cy = lim_y[COORD_BITS-1:0];
    end else begin
      cy = sum_y[COORD_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    pos_d      = pos_q;
    flag_d     = flag_q;
    xbyte_d    = xbyte_q;
    px_d       = px_q;
    py_d       = py_q;
    left_d     = left_q;
    width_d    = width_q;
    height_d   = height_q;
    byte_vld_d = byte_vld_q;
    byte_d     = byte_q;
    out_vld_d  = out_vld_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    omoved_d   = omoved_q;
    oleft_d    = oleft_q;
    ochg_d     = ochg_q;
    ext_x      = '0;
    ext_y      = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegScreenWidth:  width_d  = cfg_wdata_i;
        RegScreenHeight: height_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_free) begin
      out_vld_d = 1'b0;
    end

    if (proc_go) begin
      byte_vld_d = 1'b0;
      unique case (pos_q)
        POS_FLAGS: begin
          // resync: wait for a byte that can be a flag byte
          if (byte_q[ResyncBit]) begin
            flag_d = byte_q;
            pos_d  = POS_XDELTA;
          end
        end
        POS_XDELTA: begin
          xbyte_d = byte_q;
          pos_d   = POS_YDELTA;
        end
        POS_YDELTA: begin
          pos_d = POS_FLAGS;
          if (make_result) begin
            if (moved) begin
              px_d = cx;
              py_d = cy;
            end
            left_d    = flag_q[LeftBit];
            out_vld_d = 1'b1;
            ext_x     = SW'(moved ? cx : px_q);
            ext_y     = SW'(moved ? cy : py_q);
            ox_d      = ext_x[FieldBits-1:0];
            oy_d      = ext_y[FieldBits-1:0];
            omoved_d  = moved;
            oleft_d   = flag_q[LeftBit];
            ochg_d    = flag_q[LeftBit] ^ left_q;
          end
        end
        default: pos_d = POS_FLAGS;
      endcase
    end

    if (in_accept) begin
      byte_vld_d = 1'b1;
      byte_d     = stream_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_FLAGS;
      flag_q     <= '0;
      xbyte_q    <= '0;
      px_q       <= XReset;
      py_q       <= YReset;
      left_q     <= 1'b0;
      width_q    <= ScreenWidthReset;
      height_q   <= ScreenHeightReset;
      byte_vld_q <= 1'b0;
      byte_q     <= '0;
      out_vld_q  <= 1'b0;
      ox_q       <= '0;
      oy_q       <= '0;
      omoved_q   <= 1'b0;
      oleft_q    <= 1'b0;
      ochg_q     <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      flag_q     <= flag_d;
      xbyte_q    <= xbyte_d;
      px_q       <= px_d;
      py_q       <= py_d;
      left_q     <= left_d;
      width_q    <= width_d;
      height_q   <= height_d;
      byte_vld_q <= byte_vld_d;
      byte_q     <= byte_d;
      out_vld_q  <= out_vld_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      omoved_q   <= omoved_d;
      oleft_q    <= oleft_d;
      ochg_q     <= ochg_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign cursor_x_o       = ox_q;
  assign cursor_y_o       = oy_q;
  assign moved_o          = omoved_q;
  assign left_pressed_o   = oleft_q;
  assign button_changed_o = ochg_q;

  // only a packet-ending byte waiting on a held result may stall the input
  `PS2MCT_ASSERT_NOW(a_stall_cause, in_stall_o,
    byte_vld_q && make_result && out_vld_q && out_stall_i,
    "input stalled without a pending result")

  // a fresh result always follows a third byte
  `PS2MCT_ASSERT_NOW(a_result_after_third, $rose(out_vld_q),
    $past(load_result) && ($past(pos_q) == POS_YDELTA),
    "result without a complete packet")

  // a still packet leaves the cursor untouched
  `PS2MCT_ASSERT_NEXT(a_still_keeps_pos, load_result && !moved,
    $stable(px_q) && $stable(py_q) && !omoved_q,
    "cursor moved on a zero-motion packet")

endmodule
